// ----- design/crs_pkg.sv -----
// Shared types and constants of the congruence solver.
// Used by the controller, the datapath and the top level; depends on nothing.
package crs_pkg;

   localparam int MAX_K     = 8;
   localparam int IDX_W     = $clog2(MAX_K);
   localparam int CNT_W     = $clog2(MAX_K + 1);
   localparam int MOD_W     = 31;
   localparam int SOL_W     = 63;
   localparam int STAT_W    = 2;
   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int MUL_W     = 32;
   localparam int REQ_DW    = 64;
   localparam int RSP_DW    = 72;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_OVF  = 2'd1,
      STAT_MANY = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_PROD_INIT,
      OP_PROD_LO,
      OP_PROD_HI,
      OP_PROD_ACC,
      OP_COF_DIV,
      OP_COF_TAKE,
      OP_EU_INIT,
      OP_EU_DIV,
      OP_EU_MUL,
      OP_EU_UPD,
      OP_INV_FIX,
      OP_PART_MUL,
      OP_PART_DIV,
      OP_ACC_LO,
      OP_ACC_HI,
      OP_ACC_ADD,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   store;
   } cmd_type;

   typedef struct packed {
      logic too_many;
      logic ovf;
      logic idx_last;
      logic r_zero;
      logic div_last;
   } flags_type;

endpackage

// ----- design/crs_ctrl.sv -----
// Sequencing state machine of the congruence solver.
// Depends on crs_pkg; drives the datapath through cmd_type, reads flags_type.
module crs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  crs_pkg::flags_type  flags,
   output crs_pkg::cmd_type    cmd
);
   import crs_pkg::*;

   typedef enum logic [18:0] {
      S_IDLE     = 19'h00001,
      S_START    = 19'h00002,
      S_PROD_LO  = 19'h00004,
      S_PROD_HI  = 19'h00008,
      S_PROD_ACC = 19'h00010,
      S_COF_DIV  = 19'h00020,
      S_COF_TAKE = 19'h00040,
      S_EU_INIT  = 19'h00080,
      S_EU_TEST  = 19'h00100,
      S_EU_MUL   = 19'h00200,
      S_EU_UPD   = 19'h00400,
      S_INV_FIX  = 19'h00800,
      S_PART_MUL = 19'h01000,
      S_PART_DIV = 19'h02000,
      S_ACC_LO   = 19'h04000,
      S_ACC_HI   = 19'h08000,
      S_ACC_ADD  = 19'h10000,
      S_DIV_WAIT = 19'h20000,
      S_EMIT     = 19'h40000
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      valid_ff, valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      valid_in  = valid_ff && !rsp_tready;
      cmd.op    = OP_NONE;
      cmd.store = req_tvalid && (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tlast) state_in = S_START;
         end
         S_START: begin
            if (flags.too_many) begin
               state_in = S_EMIT;
            end else begin
               cmd.op   = OP_PROD_INIT;
               state_in = S_PROD_LO;
            end
         end
         S_PROD_LO: begin
            cmd.op   = OP_PROD_LO;
            state_in = S_PROD_HI;
         end
         S_PROD_HI: begin
            cmd.op   = OP_PROD_HI;
            state_in = S_PROD_ACC;
         end
         S_PROD_ACC: begin
            cmd.op = OP_PROD_ACC;
            priority if (flags.ovf) state_in = S_EMIT;
            else if (flags.idx_last) state_in = S_COF_DIV;
            else state_in = S_PROD_LO;
         end
         S_COF_DIV: begin
            cmd.op   = OP_COF_DIV;
            ret_in   = S_COF_TAKE;
            state_in = S_DIV_WAIT;
         end
         S_COF_TAKE: begin
            cmd.op   = OP_COF_TAKE;
            ret_in   = S_EU_INIT;
            state_in = S_DIV_WAIT;
         end
         S_EU_INIT: begin
            cmd.op   = OP_EU_INIT;
            state_in = S_EU_TEST;
         end
         S_EU_TEST: begin
            if (flags.r_zero) begin
               state_in = S_INV_FIX;
            end else begin
               cmd.op   = OP_EU_DIV;
               ret_in   = S_EU_MUL;
               state_in = S_DIV_WAIT;
            end
         end
         S_EU_MUL: begin
            cmd.op   = OP_EU_MUL;
            state_in = S_EU_UPD;
         end
         S_EU_UPD: begin
            cmd.op   = OP_EU_UPD;
            state_in = S_EU_TEST;
         end
         S_INV_FIX: begin
            cmd.op   = OP_INV_FIX;
            ret_in   = S_PART_MUL;
            state_in = S_DIV_WAIT;
         end
         S_PART_MUL: begin
            cmd.op   = OP_PART_MUL;
            state_in = S_PART_DIV;
         end
         S_PART_DIV: begin
            cmd.op   = OP_PART_DIV;
            ret_in   = S_ACC_LO;
            state_in = S_DIV_WAIT;
         end
         S_ACC_LO: begin
            cmd.op   = OP_ACC_LO;
            state_in = S_ACC_HI;
         end
         S_ACC_HI: begin
            cmd.op   = OP_ACC_HI;
            state_in = S_ACC_ADD;
         end
         S_ACC_ADD: begin
            cmd.op   = OP_ACC_ADD;
            state_in = flags.idx_last ? S_EMIT : S_COF_DIV;
         end
         S_DIV_WAIT: begin
            if (flags.div_last) state_in = ret_ff;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!valid_ff || rsp_tready) begin
               cmd.op   = OP_EMIT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- design/crs_dp.sv -----
// Datapath of the congruence solver: pair store, product, shared restoring
// divider, shared 32x32 multiplier, Euclid registers and accumulator. Uses crs_pkg.
module crs_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  crs_pkg::cmd_type           cmd,
   input  logic [crs_pkg::MOD_W-1:0]  modulus,
   input  logic [crs_pkg::MOD_W-1:0]  remainder,
   output crs_pkg::flags_type         flags,
   output logic [crs_pkg::SOL_W-1:0]  solution,
   output crs_pkg::status_type        status
);
   import crs_pkg::*;

   logic [MOD_W-1:0]     mod_mem_ff [MAX_K];
   logic [MOD_W-1:0]     rem_mem_ff [MAX_K];
   logic [CNT_W-1:0]     cnt_ff;
   logic                 many_ff;
   logic                 ovf_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [SOL_W-1:0]     prod_ff, res_ff, cof_ff, sol_ff;
   status_type           stat_ff;
   logic [2*MUL_W-1:0]   mul_ff, lo_ff;
   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [MOD_W-1:0]     g_ff, r_ff, inv_ff;
   logic [MUL_W-1:0]     s_ff, t_ff;
   logic [DIV_W-1:0]     div_num_ff;
   logic [MOD_W-1:0]     div_rem_ff, div_dvs_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   logic [MOD_W-1:0]     m_cur, r_cur;
   logic [3*MUL_W-1:0]   wide;
   logic [SOL_W:0]       sum, sum_red;
   logic                 div_start;
   logic [DIV_W-1:0]     div_arg;
   logic [MOD_W-1:0]     div_by;
   logic [MOD_W:0]       div_try;
   logic                 div_ge;
   logic [MUL_W-1:0]     t_mag;
   logic [2*MUL_W-1:0]   tq, nt;
   logic [MUL_W-1:0]     s_pos;

   assign m_cur = mod_mem_ff[idx_ff];
   assign r_cur = rem_mem_ff[idx_ff];

   // high partial product shifted up, plus the low one
   assign wide = {mul_ff, {MUL_W{1'b0}}} + {{MUL_W{1'b0}}, lo_ff};

   assign sum     = {1'b0, res_ff} + wide[SOL_W:0];
   assign sum_red = (sum >= {1'b0, prod_ff}) ? (sum - {1'b0, prod_ff}) : sum;

   assign t_mag = t_ff[MUL_W-1] ? (~t_ff + 1'b1) : t_ff;
   assign tq    = t_ff[MUL_W-1] ? (~mul_ff + 1'b1) : mul_ff;
   assign nt    = {{MUL_W{s_ff[MUL_W-1]}}, s_ff} - tq;
   assign s_pos = s_ff + {1'b0, m_cur};

   assign div_try = {div_rem_ff, div_num_ff[DIV_W-1]};
   assign div_ge  = div_try >= {1'b0, div_dvs_ff};

   assign flags.too_many = many_ff;
   assign flags.ovf      = |wide[3*MUL_W-1:SOL_W];
   assign flags.idx_last = (CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff;
   assign flags.r_zero   = (r_ff == '0);
   assign flags.div_last = (div_cnt_ff == DIV_CNT_W'(1));

   assign solution = sol_ff;
   assign status   = stat_ff;

   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_arg   = '0;
      div_by    = m_cur;
      unique case (cmd.op)
         OP_PROD_LO: begin
            mul_a = prod_ff[MUL_W-1:0];
            mul_b = {1'b0, m_cur};
         end
         OP_PROD_HI: begin
            mul_a = {1'b0, prod_ff[SOL_W-1:MUL_W]};
            mul_b = {1'b0, m_cur};
         end
         OP_COF_DIV: begin
            div_start = 1'b1;
            div_arg   = {1'b0, prod_ff};
         end
         OP_COF_TAKE: begin
            div_start = 1'b1;
            div_arg   = {1'b0, div_num_ff[SOL_W-1:0]};
         end
         OP_EU_DIV: begin
            div_start = 1'b1;
            div_arg   = {{(DIV_W-MOD_W){1'b0}}, g_ff};
            div_by    = r_ff;
         end
         OP_EU_MUL: begin
            mul_a = t_mag;
            mul_b = div_num_ff[MUL_W-1:0];
         end
         OP_INV_FIX: begin
            div_start = 1'b1;
            div_arg   = {{(DIV_W-MOD_W){1'b0}}, r_cur};
         end
         OP_PART_MUL: begin
            mul_a = {1'b0, div_rem_ff};
            mul_b = {1'b0, inv_ff};
         end
         OP_PART_DIV: begin
            div_start = 1'b1;
            div_arg   = mul_ff;
         end
         OP_ACC_LO: begin
            mul_a = cof_ff[MUL_W-1:0];
            mul_b = {1'b0, div_rem_ff};
         end
         OP_ACC_HI: begin
            mul_a = {1'b0, cof_ff[SOL_W-1:MUL_W]};
            mul_b = {1'b0, div_rem_ff};
         end
         default: begin
         end
      endcase
   end

   // pair store and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         many_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         cnt_ff  <= '0;
         many_ff <= 1'b0;
      end else if (cmd.store) begin
         if (cnt_ff < CNT_W'(MAX_K)) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else begin
            many_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && (cnt_ff < CNT_W'(MAX_K))) begin
         // a zero modulus places no constraint
         mod_mem_ff[cnt_ff[IDX_W-1:0]] <= (modulus == '0) ? MOD_W'(1) : modulus;
         rem_mem_ff[cnt_ff[IDX_W-1:0]] <= remainder;
      end
   end

   // shared restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (div_start) begin
         div_cnt_ff <= DIV_CNT_W'(DIV_W);
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         div_num_ff <= div_arg;
         div_rem_ff <= '0;
         div_dvs_ff <= div_by;
      end else if (div_cnt_ff != '0) begin
         div_num_ff <= {div_num_ff[DIV_W-2:0], div_ge};
         div_rem_ff <= div_ge ? MOD_W'(div_try - {1'b0, div_dvs_ff}) : div_try[MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff <= 1'b0;
      end else if (cmd.op == OP_PROD_INIT || cmd.op == OP_EMIT) begin
         ovf_ff <= 1'b0;
      end else if (cmd.op == OP_PROD_ACC && flags.ovf) begin
         ovf_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_PROD_INIT: begin
            prod_ff <= SOL_W'(1);
            res_ff  <= '0;
            idx_ff  <= '0;
         end
         OP_PROD_HI: lo_ff <= mul_ff;
         OP_PROD_ACC: begin
            if (!flags.ovf) prod_ff <= wide[SOL_W-1:0];
            idx_ff <= flags.idx_last ? '0 : idx_ff + IDX_W'(1);
         end
         OP_COF_TAKE: cof_ff <= div_num_ff[SOL_W-1:0];
         OP_EU_INIT: begin
            g_ff <= m_cur;
            r_ff <= div_rem_ff;
            s_ff <= '0;
            t_ff <= MUL_W'(1);
         end
         OP_EU_UPD: begin
            g_ff <= r_ff;
            r_ff <= div_rem_ff;
            s_ff <= t_ff;
            t_ff <= nt[MUL_W-1:0];
         end
         OP_INV_FIX: begin
            // no inverse unless gcd is one; lift a negative one by the modulus
            if (g_ff != MOD_W'(1)) inv_ff <= '0;
            else if (s_ff[MUL_W-1]) inv_ff <= s_pos[MOD_W-1:0];
            else inv_ff <= s_ff[MOD_W-1:0];
         end
         OP_ACC_HI: lo_ff <= mul_ff;
         OP_ACC_ADD: begin
            res_ff <= sum_red[SOL_W-1:0];
            idx_ff <= flags.idx_last ? '0 : idx_ff + IDX_W'(1);
         end
         OP_EMIT: begin
            priority if (many_ff) begin
               sol_ff  <= '0;
               stat_ff <= STAT_MANY;
            end else if (ovf_ff) begin
               sol_ff  <= '0;
               stat_ff <= STAT_OVF;
            end else begin
               sol_ff  <= res_ff;
               stat_ff <= STAT_OK;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- design/chinese_remainder_solver.sv -----
// Top level of the congruence solver: stream ports, controller and datapath.
// Depends on crs_pkg, crs_ctrl and crs_dp.
//
//   port group  direction  contents
//   req_*       in         modulus, remainder in tdata; last pair in tlast
//   rsp_*       out        solution and status in tdata, one item per set
//
// A pair that is not last is stored and the controller stays idle. A last pair
// starts the solve: a start state, the product states (low, high, accumulate)
// for each pair, then per pair (4 + E) divisions on the shared 64-step restoring
// divider, E being the number of Euclid steps (at most about 45 for 31-bit moduli),
// plus multiply and update states per Euclid step, and an emit state at the end.
// Reset is synchronous; no memory clearing pass. req_tready is low while
// solving; a finished item waits in the output register while pairs are taken.
module chinese_remainder_solver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [30:0] modulus, [61:31] remainder, [63:62] zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [62:0] solution, [64:63] status, [71:65] zero
);
   import crs_pkg::*;

   cmd_type             cmd;
   flags_type           flags;
   logic [SOL_W-1:0]    solution;
   status_type          status;

   crs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   crs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .modulus   (req_tdata[MOD_W-1:0]),
      .remainder (req_tdata[2*MOD_W-1:MOD_W]),
      .flags     (flags),
      .solution  (solution),
      .status    (status)
   );

   assign rsp_tdata = {{(RSP_DW-SOL_W-STAT_W){1'b0}}, status, solution};

endmodule

// ----- design/crs_checker.sv -----
// Port-level checks for the congruence solver, bound to the top level.
// Depends on the top level's ports only.
module crs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[64:63] != 2'd3)
      else $error("undefined status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64:63] != 2'd0 |-> rsp_tdata[62:0] == 63'd0)
      else $error("failed solve carries a non-zero solution");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken during a solve");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind chinese_remainder_solver crs_checker u_crs_checker (.*);
